/* hdl/keyed_barrier_table_unit_assert.svh */
// Assertion macros used by the barrier table back end.
`ifndef KEYED_BARRIER_TABLE_UNIT_ASSERT_SVH
`define KEYED_BARRIER_TABLE_UNIT_ASSERT_SVH

// The expression must hold at every clock edge outside reset.
`define KBT_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// When the antecedent holds, the consequent holds in the same cycle.
`define KBT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define KBT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/kbt_pkg.sv */
package kbt_pkg;

    localparam int NUM_BARRIERS = 16;
    localparam int BAR_W        = $clog2(NUM_BARRIERS);
    localparam int LIVE_W       = $clog2(NUM_BARRIERS + 1);

    localparam int OP_W   = 2;
    localparam int KEY_W  = 32;
    localparam int THR_W  = 16;
    localparam int IDX_W  = 4;
    localparam int SLOT_W = 4;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 8;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [OP_W-1:0] {
        OP_CREATE = 2'd0,
        OP_HIT    = 2'd1,
        OP_DELETE = 2'd2,
        OP_LOOKUP = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_NOKEY  = 2'd2,
        ST_UNUSED = 2'd3
    } t_status;

    typedef enum logic {
        BK_IDLE,
        BK_EXEC
    } t_back_state;

    typedef struct packed {
        t_op               op;
        logic [KEY_W-1:0]  key;
        logic [THR_W-1:0]  thr;
        logic [IDX_W-1:0]  idx;
    } t_req;

    // Packed so that status sits in the lowest bits of the result bus.
    typedef struct packed {
        logic              must_block;
        logic              release_all;
        logic [SLOT_W-1:0] slot;
        t_status           status;
    } t_rsp;

    typedef struct packed {
        logic             found;
        logic [BAR_W-1:0] idx;
    } t_find;

    // Lowest set bit of a slot vector.
    function automatic t_find lowest_set(input logic [NUM_BARRIERS-1:0] v);
        t_find res;
        res.found = 1'b0;
        res.idx   = '0;
        for (int i = NUM_BARRIERS - 1; i >= 0; i--) begin
            if (v[i]) begin
                res.found = 1'b1;
                res.idx   = BAR_W'(i);
            end
        end
        return res;
    endfunction

endpackage

/* hdl/kbt_front.sv */
module kbt_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [kbt_pkg::OP_W-1:0]      i_op_bits,
    input  logic [kbt_pkg::IN_TDATA_W-1:0] i_data,
    output logic                          o_q_valid,
    input  logic                          i_q_pop,
    output kbt_pkg::t_req                 o_q_req
);
    import kbt_pkg::*;

    t_req              r_ent [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    t_req              w_req;
    t_op               w_op;
    logic              w_push;
    logic              w_pop;

    // Decode the operation code into its class.
    always_comb begin
        case (i_op_bits)
            OP_CREATE: w_op = OP_CREATE;
            OP_HIT:    w_op = OP_HIT;
            OP_DELETE: w_op = OP_DELETE;
            default:   w_op = OP_LOOKUP;
        endcase
    end

    assign w_req.op  = w_op;
    assign w_req.key = i_data[KEY_W-1:0];
    assign w_req.thr = i_data[KEY_W+THR_W-1:KEY_W];
    assign w_req.idx = i_data[KEY_W+THR_W+IDX_W-1:KEY_W+THR_W];

    assign o_ready   = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_q_valid = (r_count != '0);
    assign o_q_req   = r_ent[r_rd_ptr];
    assign w_push    = i_valid && o_ready;
    assign w_pop     = i_q_pop && o_q_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_ent[r_wr_ptr] <= w_req;
        end
    end

endmodule

/* hdl/kbt_back.sv */
`include "keyed_barrier_table_unit_assert.svh"

module kbt_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    output logic          o_q_pop,
    input  kbt_pkg::t_req i_q_req,
    output logic          o_valid,
    input  logic          i_ready,
    output kbt_pkg::t_rsp o_rsp
);
    import kbt_pkg::*;

    t_back_state              r_state, n_state;
    t_req                     r_req;
    logic [NUM_BARRIERS-1:0]  r_match;
    logic [NUM_BARRIERS-1:0]  r_valid;
    logic [KEY_W-1:0]         r_key   [NUM_BARRIERS];
    logic [THR_W-1:0]         r_thr   [NUM_BARRIERS];
    logic [THR_W-1:0]         r_arr   [NUM_BARRIERS];
    logic [LIVE_W-1:0]        r_live;
    logic                     r_out_valid;
    t_rsp                     r_out;

    logic                     w_load;
    logic                     w_commit;
    logic [NUM_BARRIERS-1:0]  w_key_eq;
    t_find                    w_free;
    t_find                    w_hit_key;
    logic                     w_full;
    logic [BAR_W-1:0]         w_hidx;
    logic                     w_hit_ok;
    logic [THR_W-1:0]         w_next_cnt;
    logic                     w_reached;
    t_rsp                     w_rsp;

    // Key compare against every slot; the priority pick waits for the next cycle.
    always_comb begin
        for (int i = 0; i < NUM_BARRIERS; i++) begin
            w_key_eq[i] = r_valid[i] && (r_key[i] == i_q_req.key);
        end
    end

    always_comb begin
        case (r_state)
            BK_IDLE: n_state = i_q_valid ? BK_EXEC : BK_IDLE;
            BK_EXEC: n_state = w_commit ? BK_IDLE : BK_EXEC;
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        w_load   = 1'b0;
        w_commit = 1'b0;
        case (r_state)
            BK_IDLE: w_load   = i_q_valid;
            BK_EXEC: w_commit = !r_out_valid || i_ready;
            default: begin
                w_load   = 1'b0;
                w_commit = 1'b0;
            end
        endcase
    end

    assign o_q_pop = w_load;

    assign w_free     = lowest_set(~r_valid);
    assign w_hit_key  = lowest_set(r_match);
    assign w_full     = (r_live == LIVE_W'(NUM_BARRIERS));
    assign w_hidx     = BAR_W'(r_req.idx);
    assign w_hit_ok   = ({{(32-IDX_W){1'b0}}, r_req.idx} < 32'(NUM_BARRIERS))
                        && r_valid[w_hidx];
    // The arrival count saturates at its top value.
    assign w_next_cnt = (r_arr[w_hidx] == {THR_W{1'b1}}) ? r_arr[w_hidx]
                                                         : r_arr[w_hidx] + 1'b1;
    assign w_reached  = (w_next_cnt >= r_thr[w_hidx]);

    always_comb begin
        w_rsp.status      = ST_OK;
        w_rsp.slot        = '0;
        w_rsp.release_all = 1'b0;
        w_rsp.must_block  = 1'b0;
        case (r_req.op)
            OP_CREATE: begin
                if (w_full) begin
                    w_rsp.status = ST_FULL;
                end else begin
                    w_rsp.slot = SLOT_W'(w_free.idx);
                end
            end
            OP_HIT: begin
                if (!w_hit_ok) begin
                    w_rsp.status = ST_UNUSED;
                end else begin
                    w_rsp.release_all = w_reached;
                    w_rsp.must_block  = !w_reached;
                end
            end
            OP_DELETE: begin
                if (!w_hit_key.found) begin
                    w_rsp.status = ST_NOKEY;
                end
            end
            OP_LOOKUP: begin
                if (!w_hit_key.found) begin
                    w_rsp.status = ST_NOKEY;
                end else begin
                    w_rsp.slot = SLOT_W'(w_hit_key.idx);
                end
            end
            default: w_rsp.status = ST_OK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_valid     <= '0;
            r_live      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_commit) begin
                case (r_req.op)
                    OP_CREATE: begin
                        if (!w_full) begin
                            r_valid[w_free.idx] <= 1'b1;
                            r_live              <= r_live + 1'b1;
                        end
                    end
                    OP_DELETE: begin
                        if (w_hit_key.found) begin
                            r_valid[w_hit_key.idx] <= 1'b0;
                            if (r_live != '0) begin
                                r_live <= r_live - 1'b1;
                            end
                        end
                    end
                    default: r_live <= r_live;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_req   <= i_q_req;
            r_match <= w_key_eq;
        end
        if (w_commit) begin
            r_out <= w_rsp;
            case (r_req.op)
                OP_CREATE: begin
                    if (!w_full) begin
                        r_key[w_free.idx] <= r_req.key;
                        r_thr[w_free.idx] <= r_req.thr;
                        r_arr[w_free.idx] <= '0;
                    end
                end
                OP_HIT: begin
                    if (w_hit_ok) begin
                        r_arr[w_hidx] <= w_reached ? '0 : w_next_cnt;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

    `KBT_ASSERT_ALWAYS(a_live_matches_valid, i_clk, i_rst_n,
        r_live == LIVE_W'($countones(r_valid)), "live count disagrees with valid slots")
    `KBT_ASSERT_NEXT(a_create_sets_slot, i_clk, i_rst_n,
        w_commit && (r_req.op == OP_CREATE) && !w_full,
        r_valid[$past(w_free.idx)], "create did not mark its slot in use")
    `KBT_ASSERT_IMPLIES(a_release_block_excl, i_clk, i_rst_n,
        r_out_valid, !(r_out.release_all && r_out.must_block), "release and block together")
    `KBT_ASSERT_IMPLIES(a_error_slot_zero, i_clk, i_rst_n,
        r_out_valid && (r_out.status != ST_OK), r_out.slot == '0, "error result has a slot")

endmodule

/* hdl/keyed_barrier_table_unit.sv */
// A request is held in the queue once accepted; the table engine then loads it
// with its key compare and executes it into the output register when the output side is ready.
// The table engine takes no new request until it has executed the last one;
// a 2-entry queue lets the input run ahead meanwhile.
// Reset (synchronous, active low) frees every slot, zeroes the live count and
// empties the queue and the output register.
module keyed_barrier_table_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // [31:0] key, [47:32] threshold, [51:48] barrier_index, [55:52] zero
    input  logic [kbt_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // [1:0] operation
    input  logic [kbt_pkg::OP_W-1:0]        i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [1:0] status, [5:2] slot, [6] release_all, [7] must_block
    output logic [kbt_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);
    import kbt_pkg::*;

    logic w_q_valid;
    logic w_q_pop;
    t_req w_q_req;
    t_rsp w_rsp;

    kbt_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_op_bits (i_s_axis_tuser),
        .i_data    (i_s_axis_tdata),
        .o_q_valid (w_q_valid),
        .i_q_pop   (w_q_pop),
        .o_q_req   (w_q_req)
    );

    kbt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .o_q_pop   (w_q_pop),
        .i_q_req   (w_q_req),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_rsp     (w_rsp)
    );

    assign o_m_axis_tdata = OUT_TDATA_W'(w_rsp);

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;
    import kbt_pkg::*;

    localparam int KEY_POOL_SIZE = 10;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // [31:0] key, [47:32] threshold, [51:48] barrier_index, [55:52] zero
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    // [1:0] operation
    logic [OP_W-1:0]        s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // [1:0] status, [5:2] slot, [6] release_all, [7] must_block
    logic [OUT_TDATA_W-1:0] m_tdata;

    // Shadow copy of the barrier table.
    logic                   bar_valid [NUM_BARRIERS];
    logic [KEY_W-1:0]       bar_key [NUM_BARRIERS];
    logic [THR_W-1:0]       bar_thr [NUM_BARRIERS];
    logic [THR_W-1:0]       bar_arrivals [NUM_BARRIERS];

    t_req                   pending_requests [$];
    t_rsp                   predicted_responses [$];
    logic [KEY_W-1:0]       key_pool [KEY_POOL_SIZE];
    int                     send_idle_pct = 27;
    int                     recv_idle_pct = 83;
    bit                     req_taken = 1'b0;
    int                     mismatch_count = 0;

    keyed_barrier_table_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    always #6 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("%0t: mismatch in %s: got %0h, want %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    function automatic int find_barrier(input logic [KEY_W-1:0] k);
        int hit;
        hit = -1;
        for (int i = NUM_BARRIERS - 1; i >= 0; i--) begin
            if (bar_valid[i] && bar_key[i] == k) hit = i;
        end
        return hit;
    endfunction

    // Applies one request to the shadow table and returns the response it should get.
    function automatic t_rsp barrier_table_step(input t_req r);
        t_rsp        rsp;
        int          hit;
        int unsigned cnt;
        rsp = '0;
        rsp.status = ST_OK;
        case (r.op)
            OP_CREATE: begin
                hit = -1;
                for (int i = NUM_BARRIERS - 1; i >= 0; i--) begin
                    if (!bar_valid[i]) hit = i;
                end
                if (hit < 0) begin
                    rsp.status = ST_FULL;
                end else begin
                    bar_valid[hit]    = 1'b1;
                    bar_key[hit]      = r.key;
                    bar_thr[hit]      = r.thr;
                    bar_arrivals[hit] = '0;
                    rsp.slot          = SLOT_W'(hit);
                end
            end
            OP_HIT: begin
                if (int'(r.idx) >= NUM_BARRIERS || !bar_valid[r.idx]) begin
                    rsp.status = ST_UNUSED;
                end else begin
                    cnt = 32'(bar_arrivals[r.idx]) + 1;
                    if (cnt > 32'hFFFF) cnt = 32'hFFFF;
                    if (cnt >= 32'(bar_thr[r.idx])) begin
                        rsp.release_all     = 1'b1;
                        bar_arrivals[r.idx] = '0;
                    end else begin
                        rsp.must_block      = 1'b1;
                        bar_arrivals[r.idx] = THR_W'(cnt);
                    end
                end
            end
            default: begin
                hit = find_barrier(r.key);
                if (hit < 0) begin
                    rsp.status = ST_NOKEY;
                end else if (r.op == OP_DELETE) begin
                    bar_valid[hit] = 1'b0;
                end else begin
                    rsp.slot = SLOT_W'(hit);
                end
            end
        endcase
        return rsp;
    endfunction

    task automatic push_request(input t_op op, input logic [KEY_W-1:0] k,
                                input logic [THR_W-1:0] thr, input logic [IDX_W-1:0] idx);
        t_req r;
        r.op  = op;
        r.key = k;
        r.thr = thr;
        r.idx = idx;
        pending_requests.push_back(r);
    endtask

    // Keys mostly come from a small pool so that deletes and lookups find them.
    task automatic queue_random_block(input int n, input bit filling);
        int               pick;
        t_op              op;
        logic [KEY_W-1:0] k;
        logic [THR_W-1:0] thr;
        for (int j = 0; j < n; j++) begin
            pick = $urandom_range(99);
            if (filling)
                op = pick < 45 ? OP_CREATE : pick < 75 ? OP_HIT : pick < 87 ? OP_DELETE : OP_LOOKUP;
            else
                op = pick < 10 ? OP_CREATE : pick < 40 ? OP_HIT : pick < 80 ? OP_DELETE : OP_LOOKUP;
            k = $urandom_range(99) < 85 ? key_pool[$urandom_range(KEY_POOL_SIZE - 1)] : $urandom();
            pick = $urandom_range(99);
            thr = pick < 70 ? THR_W'($urandom_range(4)) :
                  pick < 90 ? THR_W'($urandom_range(20)) : THR_W'($urandom());
            push_request(op, k, thr, IDX_W'($urandom_range(15)));
        end
    endtask

    task automatic wait_until_drained();
        while (pending_requests.size() != 0 || s_tvalid || predicted_responses.size() != 0)
            @(posedge i_clk);
    endtask

    // Driver: presents requests from the pending queue at the falling edge.
    always @(negedge i_clk) begin
        t_req r;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || req_taken) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                r = pending_requests.pop_front();
                s_tdata  <= {4'b0, r.idx, r.thr, r.key};
                s_tuser  <= r.op;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= $urandom_range(99) >= recv_idle_pct;
    end

    // Monitor: predicts each accepted request and checks each accepted response.
    always @(posedge i_clk) begin
        t_req r;
        t_rsp got;
        t_rsp want;
        req_taken = i_rst_n && s_tvalid && s_tready;
        if (req_taken) begin
            r.op  = t_op'(s_tuser);
            r.key = s_tdata[31:0];
            r.thr = s_tdata[47:32];
            r.idx = s_tdata[51:48];
            predicted_responses.push_back(barrier_table_step(r));
        end
        if (i_rst_n && m_tvalid && m_tready) begin
            got = t_rsp'(m_tdata);
            if (predicted_responses.size() == 0) begin
                report_mismatch("response with no request outstanding", 16'(m_tdata), 16'h0);
            end else begin
                want = predicted_responses.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", 16'(got.status), 16'(want.status));
                if (got.slot !== want.slot)
                    report_mismatch("slot", 16'(got.slot), 16'(want.slot));
                if (got.release_all !== want.release_all)
                    report_mismatch("release_all", 16'(got.release_all), 16'(want.release_all));
                if (got.must_block !== want.must_block)
                    report_mismatch("must_block", 16'(got.must_block), 16'(want.must_block));
            end
        end
    end

    initial begin
        for (int i = 0; i < NUM_BARRIERS; i++) begin
            bar_valid[i]    = 1'b0;
            bar_key[i]      = '0;
            bar_thr[i]      = '0;
            bar_arrivals[i] = '0;
        end
        for (int i = 0; i < KEY_POOL_SIZE; i++) key_pool[i] = $urandom();
        key_pool[0] = '0;
        key_pool[1] = '1;

        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Zero threshold releases on the first hit; duplicates resolve to the lowest slot.
        push_request(OP_CREATE, 32'h0, 16'h0, 4'h0);
        push_request(OP_HIT, 32'hFFFF_FFFF, 16'hFFFF, 4'h0);
        push_request(OP_CREATE, 32'hFFFF_FFFF, 16'hFFFF, 4'hF);
        push_request(OP_HIT, 32'h0, 16'h0, 4'h1);
        push_request(OP_CREATE, 32'h0, 16'h2, 4'h0);
        push_request(OP_LOOKUP, 32'h0, 16'h0, 4'h0);
        push_request(OP_DELETE, 32'h0, 16'h0, 4'h0);
        push_request(OP_LOOKUP, 32'h0, 16'h0, 4'h0);
        push_request(OP_HIT, 32'h0, 16'h0, 4'h0);
        push_request(OP_HIT, 32'h0, 16'h0, 4'hF);
        push_request(OP_DELETE, 32'h1234_5678, 16'h0, 4'h0);
        push_request(OP_HIT, 32'h0, 16'h0, 4'h2);
        push_request(OP_HIT, 32'h0, 16'h0, 4'h2);
        // Fill every free slot, then one more create finds the table full.
        for (int i = 0; i < NUM_BARRIERS - 2; i++)
            push_request(OP_CREATE, 32'h100 + i, THR_W'(i), 4'h0);
        push_request(OP_CREATE, 32'hA5A5_5A5A, 16'h1, 4'h0);
        wait_until_drained();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = phase == 0 ? 27 : phase == 1 ? 83 : 0;
            recv_idle_pct = phase == 0 ? 83 : phase == 1 ? 27 : 0;
            for (int blk = 0; blk < 15; blk++) queue_random_block(40, blk % 2 == 0);
            // The sender holds off here until every response of the phase is back.
            wait_until_drained();
        end

        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #5000000;
        $display("FAILURE");
        $finish;
    end

endmodule

/* keyed_barrier_table_unit.f */
+incdir+hdl
hdl/kbt_pkg.sv
hdl/kbt_front.sv
hdl/kbt_back.sv
hdl/keyed_barrier_table_unit.sv
test/tb.sv
